/* sv/fir25_pkg.sv */
// Shared types, constants and the coefficient table for the 25-tap FIR filter.
// Depends on nothing; every other file of the filter refers to it by scoped names.
package fir25_pkg;

  localparam int TAPS_DEF        = 25;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_TAPS        = 64;
  localparam int COEF_IDX_W      = $clog2(MAX_TAPS);
  localparam int COEF_BITS       = 16;
  localparam int COEF_FRAC       = 15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } fir_state_t;

  typedef struct packed {
    logic in_ready;
    logic acc_clr;
    logic mul_en;
    logic shift_in;
    logic rotate;
    logic use_new;
    logic load_out;
  } seq_ctrl_t;

  // Q1.15 coefficients, nearest integer to c * 32768; taps past the table are zero.
  function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
    logic signed [COEF_BITS-1:0] c;
    unique case (idx)
      COEF_IDX_W'(2):  c = 16'sd33;
      COEF_IDX_W'(3):  c = -16'sd66;
      COEF_IDX_W'(4):  c = -16'sd66;
      COEF_IDX_W'(5):  c = 16'sd328;
      COEF_IDX_W'(6):  c = -16'sd295;
      COEF_IDX_W'(7):  c = -16'sd590;
      COEF_IDX_W'(8):  c = 16'sd1606;
      COEF_IDX_W'(9):  c = -16'sd655;
      COEF_IDX_W'(10): c = 16'sd3604;
      COEF_IDX_W'(11): c = 16'sd9175;
      COEF_IDX_W'(12): c = 16'sd20972;
      COEF_IDX_W'(13): c = 16'sd9175;
      COEF_IDX_W'(14): c = -16'sd3604;
      COEF_IDX_W'(15): c = -16'sd655;
      COEF_IDX_W'(16): c = 16'sd1606;
      COEF_IDX_W'(17): c = -16'sd590;
      COEF_IDX_W'(18): c = -16'sd295;
      COEF_IDX_W'(19): c = 16'sd328;
      COEF_IDX_W'(20): c = -16'sd66;
      COEF_IDX_W'(21): c = -16'sd66;
      COEF_IDX_W'(22): c = 16'sd33;
      default:         c = '0;
    endcase
    return c;
  endfunction

endpackage

/* sv/fir25_if.sv */
// Valid/ready channel interfaces for the filter's sample input and filtered output.
// Depends on fir25_pkg for the default sample width.
interface fir25_in_if #(
  parameter int SAMPLE_BITS = fir25_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fir25_out_if #(
  parameter int SAMPLE_BITS = fir25_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

/* sv/fir25_dline.sv */
// Sample delay line: shift in a new sample or rotate the line by one place.
// Depends on fir25_pkg for the control struct.
module fir25_dline #(
  parameter int SAMPLE_BITS = fir25_pkg::SAMPLE_BITS_DEF,
  parameter int TAPS        = fir25_pkg::TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fir25_pkg::seq_ctrl_t          ctrl,
  input  logic signed [SAMPLE_BITS-1:0] din,
  output logic signed [SAMPLE_BITS-1:0] tail
);

  localparam int LEN = (TAPS > 1) ? TAPS - 1 : 1;

  logic signed [SAMPLE_BITS-1:0] line_r [LEN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEN; i++) line_r[i] <= '0;
    end else if (ctrl.shift_in || ctrl.rotate) begin
      for (int i = 1; i < LEN; i++) line_r[i] <= line_r[i-1];
      // rotate feeds the oldest entry back to the head
      line_r[0] <= ctrl.shift_in ? din : line_r[LEN-1];
    end
  end

  assign tail = line_r[LEN-1];

endmodule

/* sv/fir25_mac.sv */
// Shared multiply-accumulate unit with round-half-up and saturation to the sample range.
// Depends on fir25_pkg for coefficient table, widths and the control struct.
module fir25_mac #(
  parameter int SAMPLE_BITS = fir25_pkg::SAMPLE_BITS_DEF,
  parameter int TAPS        = fir25_pkg::TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fir25_pkg::seq_ctrl_t                 ctrl,
  input  logic [fir25_pkg::COEF_IDX_W-1:0]     coef_idx,
  input  logic signed [SAMPLE_BITS-1:0]        new_sample,
  input  logic signed [SAMPLE_BITS-1:0]        tail,
  output logic signed [SAMPLE_BITS-1:0]        result
);

  localparam int PROD_W = SAMPLE_BITS + fir25_pkg::COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
  localparam int SH_W   = ACC_W + 1 - fir25_pkg::COEF_FRAC;

  localparam logic signed [SH_W-1:0] SAT_MAX =
    {{(SH_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_MIN =
    {{(SH_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic signed [ACC_W:0] HALF =
    (ACC_W + 1)'(1) <<< (fir25_pkg::COEF_FRAC - 1);

  logic signed [SAMPLE_BITS-1:0]         operand;
  logic signed [fir25_pkg::COEF_BITS-1:0] coef;
  logic signed [PROD_W-1:0]              prod_r;
  logic                                  prod_vld_r;
  logic signed [ACC_W-1:0]               acc_r;
  logic signed [ACC_W:0]                 biased;
  logic signed [SH_W-1:0]                shifted;

  assign operand = ctrl.use_new ? new_sample : tail;
  assign coef    = fir25_pkg::coef_at(coef_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) prod_r <= PROD_W'(operand) * PROD_W'(coef);
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // add half an LSB, then floor shift
  assign biased  = (ACC_W + 1)'(acc_r) + HALF;
  assign shifted = SH_W'(biased >>> fir25_pkg::COEF_FRAC);

  always_comb begin
    priority if (shifted > SAT_MAX) result = SAT_MAX[SAMPLE_BITS-1:0];
    else if (shifted < SAT_MIN)     result = SAT_MIN[SAMPLE_BITS-1:0];
    else                            result = shifted[SAMPLE_BITS-1:0];
  end

endmodule

/* sv/fir25_seq.sv */
// Sequencer for the filter: steps the shared MAC over all taps, then rounds.
// Depends on fir25_pkg for the state enum and the control struct.
module fir25_seq #(
  parameter int TAPS = fir25_pkg::TAPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             out_free,
  output fir25_pkg::seq_ctrl_t             ctrl,
  output logic [fir25_pkg::COEF_IDX_W-1:0] coef_idx
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  fir25_pkg::fir_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  last;

  assign last = (cnt_r == CNT_W'(TAPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir25_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      fir25_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (start) state_nxt = fir25_pkg::ST_MAC;
      end
      fir25_pkg::ST_MAC: begin
        if (last) begin
          state_nxt = fir25_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      fir25_pkg::ST_DRAIN: state_nxt = fir25_pkg::ST_ROUND;
      fir25_pkg::ST_ROUND: begin
        if (out_free) state_nxt = fir25_pkg::ST_IDLE;
      end
      default: state_nxt = fir25_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      fir25_pkg::ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.acc_clr  = 1'b1;
      end
      fir25_pkg::ST_MAC: begin
        ctrl.mul_en   = 1'b1;
        ctrl.shift_in = (cnt_r == '0);
        ctrl.rotate   = (cnt_r != '0);
        ctrl.use_new  = last;
      end
      fir25_pkg::ST_DRAIN: ctrl = '0;
      fir25_pkg::ST_ROUND: ctrl.load_out = out_free;
      default: ctrl = '0;
    endcase
  end

  // oldest tap first, the new sample's tap last
  assign coef_idx = fir25_pkg::COEF_IDX_W'(TAPS - 1) - fir25_pkg::COEF_IDX_W'(cnt_r);

endmodule

/* sv/fir_filter_25_tap.sv */
// Direct-form FIR filter, TAPS taps (25 by default), Q1.15 samples and coefficients.
// Each accepted request passes through these steps before the filter can take the next
// one: acceptance in the idle state, a pass over every tap, one tap at a time, through the
// single shared multiplier (oldest sample first, the new sample last), a drain step to let
// the last product into the accumulator and a round step that rounds and saturates into
// the output register. The result sits in an output register, so a new request is taken
// while a finished result still waits; only when that register is still full at the
// round step does the filter hold there. The sum is kept at full width, rounded half up
// to Q1.15 and clamped to the sample range. The delay line is zero after reset.
module fir_filter_25_tap #(
  parameter int TAPS        = fir25_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fir25_pkg::SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fir25_in_if.sink   in_chan,
  fir25_out_if.source out_chan
);

  fir25_pkg::seq_ctrl_t             ctrl;
  logic [fir25_pkg::COEF_IDX_W-1:0] coef_idx;
  logic                             accept;
  logic                             out_free;
  logic signed [SAMPLE_BITS-1:0]    sample_r;
  logic signed [SAMPLE_BITS-1:0]    tail;
  logic signed [SAMPLE_BITS-1:0]    mac_result;
  logic signed [SAMPLE_BITS-1:0]    filtered_r;
  logic                             out_valid_r;

  // a request moves when both sides agree
  assign accept   = in_chan.valid && ctrl.in_ready;
  assign in_chan.ready = ctrl.in_ready;

  // the output register can take a new result if empty or being drained this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  // hold the new sample for the whole pass: it enters the line first and is multiplied last
  always_ff @(posedge clk) begin
    if (accept) sample_r <= in_chan.sample;
  end

  fir25_seq #(
    .TAPS (TAPS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_free (out_free),
    .ctrl     (ctrl),
    .coef_idx (coef_idx)
  );

  fir25_dline #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAPS        (TAPS)
  ) u_dline (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .din   (sample_r),
    .tail  (tail)
  );

  fir25_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAPS        (TAPS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .coef_idx   (coef_idx),
    .new_sample (sample_r),
    .tail       (tail),
    .result     (mac_result)
  );

  // output register: load a rounded result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) filtered_r <= mac_result;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.filtered = filtered_r;

  // a taken request blocks the input for the whole pass
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("input ready right after a request was taken");

  // the new sample enters the delay line in the first MAC cycle
  a_shift_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ctrl.shift_in)
    else $error("delay line not shifted after accept");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> out_free)
    else $error("output register overwritten while full");

  // a pending result stays until taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(filtered_r)))
    else $error("pending result lost or changed");

endmodule

/* tb/fir_filter_25_tap_tb.sv */
// Self-checking testbench for the 25-tap Q1.15 FIR filter, fir_filter_25_tap.
// Depends on fir25_pkg for widths and on fir25_if for the sample and result channels.
`timescale 1ns / 1ps

module fir_filter_25_tap_tb;

  typedef logic signed [fir25_pkg::SAMPLE_BITS_DEF-1:0] sample_t;

  localparam int NTAPS        = fir25_pkg::TAPS_DEF;
  localparam int ITEMS_PHASE  = 510;
  localparam int DRAIN_CYCLES = 40;        // comfortably above the time one request takes
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SAMPLE_MAX   = 32767;
  localparam int SAMPLE_MIN   = -32768;

  // Scoreboard: own copy of the delay line and the Q1.15 coefficient table.
  // Each accepted request predicts one filtered sample; each result pops the oldest.
  class filter_scoreboard;
    int      coef_q15 [NTAPS];
    sample_t history [NTAPS-1];
    sample_t expected_filtered [$];
    int      errors;

    function new();
      coef_q15 = '{0, 0, 33, -66, -66, 328, -295, -590, 1606, -655, 3604, 9175, 20972,
                   9175, -3604, -655, 1606, -590, -295, 328, -66, -66, 33, 0, 0};
      foreach (history[k]) history[k] = '0;
      errors = 0;
    endfunction

    function void note_sample(sample_t x);
      longint acc;
      longint y;
      acc = longint'(x) * coef_q15[0];
      for (int k = 1; k < NTAPS; k++)
        acc += longint'(history[k-1]) * coef_q15[k];
      // round half up, arithmetic shift floors
      y = (acc + 64'sd16384) >>> 15;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      else if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      for (int k = NTAPS - 2; k > 0; k--)
        history[k] = history[k-1];
      history[0] = x;
      expected_filtered.push_back(sample_t'(y));
    endfunction

    function void check_filtered(sample_t got);
      sample_t want;
      if (expected_filtered.size() == 0) begin
        $error("filtered: no request pending, actual %0d", got);
        errors++;
        return;
      end
      want = expected_filtered.pop_front();
      if (got !== want) begin
        $error("filtered mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_filtered.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fir25_in_if  in_if ();
  fir25_out_if out_if ();

  fir_filter_25_tap dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  filter_scoreboard sb;

  int      sender_gap_pct;
  int      recv_stall_pct;
  int      run_left;
  sample_t run_value;
  int      cycles;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run: the limit is several times the slowest correct run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: throttle ready at the falling edge at the current stall rate.
  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitors sample at the rising edge, before the block's registers move.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_sample(in_if.sample);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_filtered(out_if.filtered);
  end

  // Random sample: uniform, small, single full-scale, or a held run near full
  // scale long enough to span the center taps and drive the sum into saturation.
  function automatic sample_t draw_sample();
    if (run_left != 0) begin
      run_left--;
      return run_value;
    end
    case ($urandom_range(9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5:       return sample_t'(int'($urandom_range(512)) - 256);
      6:          return $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
      7, 8: begin
        run_left  = $urandom_range(20, 8);
        run_value = $urandom_range(1) ? sample_t'(SAMPLE_MAX - int'($urandom_range(64)))
                                      : sample_t'(SAMPLE_MIN + int'($urandom_range(64)));
        return run_value;
      end
      default:    return sample_t'(int'($urandom_range(8)) - 4);
    endcase
  endfunction

  // Offer one request; enter and leave at a falling edge. Gaps drop valid,
  // and valid is never lowered and raised in the same step.
  task automatic push_sample(input sample_t s);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    out_if.ready   = 1'b0;
    sender_gap_pct = 8;
    recv_stall_pct = 51;
    run_left       = 0;
    run_value      = '0;

    // Hold reset, then release at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: full-scale positive until the center taps saturate high,
    // then full-scale negative, then zero.
    repeat (14) push_sample(sample_t'(SAMPLE_MAX));
    repeat (10) push_sample(sample_t'(SAMPLE_MIN));
    push_sample('0);
    hold_until_drained();

    // Three phases: slow receiver, slow sender, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct = (phase == 0) ? 8 : (phase == 1) ? 51 : 0;
      recv_stall_pct = (phase == 0) ? 51 : (phase == 1) ? 8 : 0;
      for (int i = 0; i < ITEMS_PHASE; i++) begin
        push_sample(draw_sample());
        // mid-phase, let the pipe run dry once before continuing
        if (i == ITEMS_PHASE / 2)
          hold_until_drained();
      end
      hold_until_drained();
    end

    // Catch any stray result after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
